/* rtl/page_to_packed_framebuffer_writer_macros.svh */
// ----------------------------------------------------------------------------
// Page to packed framebuffer writer assertion macros
// Shared property shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PAGE_TO_PACKED_FRAMEBUFFER_WRITER_MACROS_SVH
`define PAGE_TO_PACKED_FRAMEBUFFER_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTPFW_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ptpfw check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTPFW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ptpfw check failed");

`endif

/* rtl/ptpfw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page to packed framebuffer writer package
// Types, constants and helpers shared by the writer's modules.
// ----------------------------------------------------------------------------
package ptpfw_pkg;

    localparam int SRC_WIDTH        = 100;
    localparam int DEST_STRIDE_DEF  = 60;
    localparam int DEST_WIDTH_DEF   = 178;

    localparam int CENTER_X0        = 39;
    localparam int CENTER_Y0        = 32;
    localparam int CROP_X0          = 6;
    localparam int CROP_W           = 87;
    localparam int STRETCH_SPAN     = 150;

    localparam int ROW_W            = 7;
    localparam int COL_W            = 6;
    localparam int ADDR_W           = 13;
    localparam int STEP_W           = 5;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] BYTE_FIRST      = 8'b11000000;
    localparam logic [7:0] BYTE_SECOND     = 8'b00011000;
    localparam logic [7:0] BYTE_THIRD      = 8'b00000011;
    localparam logic [7:0] BYTE_WIDE_FIRST = 8'b11011000;
    localparam logic [7:0] BYTE_WIDE_THIRD = 8'b00011011;

    typedef enum logic [1:0] {
        MODE_DIRECT   = 2'd0,
        MODE_CENTERED = 2'd1,
        MODE_CROP     = 2'd2,
        MODE_STRETCH  = 2'd3
    } render_mode_t;

    typedef enum logic [1:0] {
        JOB_DIRECT  = 2'd0,
        JOB_CROP    = 2'd1,
        JOB_STRETCH = 2'd2
    } job_kind_t;

    // One queued burst of destination writes.
    typedef struct packed {
        job_kind_t          kind;
        logic [ROW_W-1:0]   row0;
        logic [COL_W-1:0]   col0;
        logic [7:0]         first;
        logic [7:0]         second;
        logic [7:0]         third;
    } job_t;

    typedef struct packed {
        logic [5:0] q;
        logic [1:0] r;
    } div3_t;

    // Divide a 7-bit value by three through a reciprocal multiply.
    function automatic div3_t div3(input logic [6:0] v);
        logic [14:0] prod;
        logic [6:0]  three_q;
        div3_t       res;
        prod    = 15'(v) * 15'd171;
        res.q   = prod[14:9];
        three_q = 7'({res.q, 1'b0}) + 7'(res.q);
        res.r   = 2'(v - three_q);
        return res;
    endfunction

endpackage

/* rtl/ptpfw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page to packed framebuffer writer front end
// Accepts source bytes, holds group members and queues write bursts.
// ----------------------------------------------------------------------------
module ptpfw_front #(
    parameter int DEST_WIDTH = ptpfw_pkg::DEST_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rstn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           in_page,
    input  logic [6:0]           in_column,
    input  logic [7:0]           in_pixels,
    input  logic                 q_full,
    output logic                 q_push,
    output ptpfw_pkg::job_t      q_job
);

    localparam int CENTER_COL    = ptpfw_pkg::CENTER_X0 / 3;
    localparam int LAST_COL_BYTE = ptpfw_pkg::SRC_WIDTH / 3;
    localparam int STRETCH_OFF   = (DEST_WIDTH - ptpfw_pkg::STRETCH_SPAN) / 6;
    localparam int TRIPLE_END    = (ptpfw_pkg::SRC_WIDTH / 3) * 3;
    localparam int PAIR_END      = (ptpfw_pkg::SRC_WIDTH / 2) * 2;
    localparam int CROP_END      = ptpfw_pkg::CROP_X0 + ptpfw_pkg::CROP_W;

    ptpfw_pkg::render_mode_t mode_reg, mode_next;
    logic [7:0] held_first_reg, held_first_next;
    logic [7:0] held_second_reg, held_second_next;

    logic                        accept;
    ptpfw_pkg::div3_t            col_div, rel_div;
    logic [6:0]                  rel_col;
    logic                        centered;
    logic [ptpfw_pkg::ROW_W-1:0] base_row;
    logic [ptpfw_pkg::COL_W-1:0] base_col;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb begin
        mode_next = mode_reg;
        if (cfg_wr_en) begin
            mode_next = ptpfw_pkg::render_mode_t'(cfg_wr_data);
        end
    end

    always_comb begin
        rel_col  = in_column - 7'(ptpfw_pkg::CROP_X0);
        col_div  = ptpfw_pkg::div3(in_column);
        rel_div  = ptpfw_pkg::div3(rel_col);
        centered = (mode_reg == ptpfw_pkg::MODE_CENTERED);
        base_row = (centered ? ptpfw_pkg::ROW_W'(ptpfw_pkg::CENTER_Y0) : '0)
                 + ptpfw_pkg::ROW_W'({in_page, 3'b000});
        base_col = centered ? ptpfw_pkg::COL_W'(CENTER_COL) : '0;

        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        q_push           = 1'b0;
        q_job.kind       = ptpfw_pkg::JOB_DIRECT;
        q_job.row0       = base_row;
        q_job.col0       = base_col;
        q_job.first      = held_first_reg;
        q_job.second     = held_second_reg;
        q_job.third      = in_pixels;

        unique case (mode_reg)
            ptpfw_pkg::MODE_DIRECT, ptpfw_pkg::MODE_CENTERED: begin
                priority if (in_column == 7'(ptpfw_pkg::SRC_WIDTH - 1)) begin
                    // The lone last column only fills the leftmost pixel slot.
                    q_push       = accept;
                    q_job.col0   = base_col + ptpfw_pkg::COL_W'(LAST_COL_BYTE);
                    q_job.first  = in_pixels;
                    q_job.second = '0;
                    q_job.third  = '0;
                end else if (in_column < 7'(TRIPLE_END)) begin
                    q_job.col0 = base_col + ptpfw_pkg::COL_W'(col_div.q);
                    unique case (col_div.r)
                        2'd0: held_first_next = accept ? in_pixels : held_first_reg;
                        2'd1: held_second_next = accept ? in_pixels : held_second_reg;
                        default: q_push = accept;
                    endcase
                end else begin
                    q_push = 1'b0;
                end
            end
            ptpfw_pkg::MODE_CROP: begin
                q_job.kind = ptpfw_pkg::JOB_CROP;
                q_job.row0 = ptpfw_pkg::ROW_W'({in_page, 4'b0000});
                q_job.col0 = ptpfw_pkg::COL_W'({rel_div.q, 1'b0});
                if (in_column >= 7'(ptpfw_pkg::CROP_X0) && in_column < 7'(CROP_END)) begin
                    unique case (rel_div.r)
                        2'd0: held_first_next = accept ? in_pixels : held_first_reg;
                        2'd1: held_second_next = accept ? in_pixels : held_second_reg;
                        default: q_push = accept;
                    endcase
                end
            end
            default: begin
                q_job.kind = ptpfw_pkg::JOB_STRETCH;
                q_job.row0 = ptpfw_pkg::ROW_W'({in_page, 4'b0000});
                q_job.col0 = ptpfw_pkg::COL_W'(STRETCH_OFF)
                           + ptpfw_pkg::COL_W'(in_column[6:1]);
                if (in_column < 7'(PAIR_END)) begin
                    if (in_column[0]) begin
                        q_push = accept;
                    end else begin
                        held_first_next = accept ? in_pixels : held_first_reg;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            mode_reg        <= ptpfw_pkg::MODE_DIRECT;
            held_first_reg  <= '0;
            held_second_reg <= '0;
        end else begin
            mode_reg        <= mode_next;
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
        end
    end

endmodule

/* rtl/ptpfw_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page to packed framebuffer writer burst queue
// Short first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module ptpfw_queue (
    input  logic             clk,
    input  logic             rstn,
    input  logic             push,
    input  ptpfw_pkg::job_t  wr_job,
    output logic             full,
    input  logic             pop,
    output logic             rd_valid,
    output ptpfw_pkg::job_t  rd_job
);

    localparam int PTR_W = $clog2(ptpfw_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ptpfw_pkg::QUEUE_DEPTH + 1);

    ptpfw_pkg::job_t   entry_reg [ptpfw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(ptpfw_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ptpfw_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ptpfw_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/ptpfw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page to packed framebuffer writer back end
// Expands each queued burst into one destination write per unstalled cycle.
// ----------------------------------------------------------------------------
module ptpfw_back #(
    parameter int DEST_STRIDE = ptpfw_pkg::DEST_STRIDE_DEF
) (
    input  logic                         clk,
    input  logic                         rstn,
    input  logic                         q_valid,
    input  ptpfw_pkg::job_t              q_job,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ptpfw_pkg::ADDR_W-1:0] out_addr,
    output logic [7:0]                   out_byte,
    output logic                         out_last
);

    logic [ptpfw_pkg::STEP_W-1:0] step_reg, step_next;
    logic                         valid_reg, valid_next;
    logic [ptpfw_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]                   byte_reg, byte_next;
    logic                         last_reg, last_next;

    logic                         advance;
    logic                         is_end;
    logic [2:0]                   bit_sel;
    logic [ptpfw_pkg::ROW_W-1:0]  row;
    logic [ptpfw_pkg::COL_W-1:0]  col;
    logic                         p1, p2, p3;

    assign advance = q_valid && (!valid_reg || out_ready);
    assign q_pop   = advance && is_end;

    always_comb begin
        row     = q_job.row0;
        col     = q_job.col0;
        bit_sel = step_reg[2:0];
        is_end  = 1'b0;
        unique case (q_job.kind)
            ptpfw_pkg::JOB_DIRECT: begin
                bit_sel = step_reg[2:0];
                row     = q_job.row0 + ptpfw_pkg::ROW_W'(bit_sel);
                is_end  = (step_reg == ptpfw_pkg::STEP_W'(7));
            end
            ptpfw_pkg::JOB_CROP: begin
                // Order per bit: left/top, right/top, left/bottom, right/bottom.
                bit_sel = step_reg[4:2];
                row     = q_job.row0 + ptpfw_pkg::ROW_W'({bit_sel, step_reg[1]});
                col     = q_job.col0 + ptpfw_pkg::COL_W'(step_reg[0]);
                is_end  = (step_reg == ptpfw_pkg::STEP_W'(31));
            end
            ptpfw_pkg::JOB_STRETCH: begin
                bit_sel = step_reg[3:1];
                row     = q_job.row0 + ptpfw_pkg::ROW_W'({bit_sel, step_reg[0]});
                is_end  = (step_reg == ptpfw_pkg::STEP_W'(15));
            end
            default: begin
                is_end = 1'b1;
            end
        endcase

        p1 = q_job.first[bit_sel];
        p2 = q_job.second[bit_sel];
        p3 = q_job.third[bit_sel];

        unique case (q_job.kind)
            ptpfw_pkg::JOB_DIRECT: begin
                byte_next = (p1 ? ptpfw_pkg::BYTE_FIRST : 8'h00)
                          | (p2 ? ptpfw_pkg::BYTE_SECOND : 8'h00)
                          | (p3 ? ptpfw_pkg::BYTE_THIRD : 8'h00);
            end
            ptpfw_pkg::JOB_CROP: begin
                if (step_reg[0]) begin
                    byte_next = (p2 ? ptpfw_pkg::BYTE_FIRST : 8'h00)
                              | (p3 ? ptpfw_pkg::BYTE_WIDE_THIRD : 8'h00);
                end else begin
                    byte_next = (p1 ? ptpfw_pkg::BYTE_WIDE_FIRST : 8'h00)
                              | (p2 ? ptpfw_pkg::BYTE_THIRD : 8'h00);
                end
            end
            default: begin
                byte_next = (p1 ? ptpfw_pkg::BYTE_WIDE_FIRST : 8'h00)
                          | (p3 ? ptpfw_pkg::BYTE_THIRD : 8'h00);
            end
        endcase

        addr_next = ptpfw_pkg::ADDR_W'(row) * ptpfw_pkg::ADDR_W'(DEST_STRIDE)
                  + ptpfw_pkg::ADDR_W'(col);
        last_next = is_end;
    end

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (advance) begin
            step_next  = is_end ? '0 : step_reg + 1'b1;
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            addr_reg <= addr_next;
            byte_reg <= byte_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_addr  = addr_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

/* rtl/page_to_packed_framebuffer_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page to packed framebuffer writer
// Turns page-organized monochrome bytes into packed three-pixel byte writes.
// ----------------------------------------------------------------------------
// Source bytes enter on the s_ channel in buffer order, one transfer per
// cycle while the burst queue has room, and each byte that closes a column
// group produces a burst of destination writes on the m_ channel: 8 writes
// in the two direct modes, 32 in crop mode and 16 in stretch mode, each
// burst ending with m_last high. The back end issues one write per cycle
// while the output is not stalled, so the sustained rate is set by the
// output port. A two-entry burst queue between the front end and the
// back end lets new bytes be taken while a burst is still being written
// out, and the registered output stage holds a write until the consumer
// takes it. The render mode register is written through cfg_wr_en /
// cfg_wr_data and must only change while no burst is pending.
// ----------------------------------------------------------------------------
module page_to_packed_framebuffer_writer #(
    parameter int DEST_STRIDE = ptpfw_pkg::DEST_STRIDE_DEF,
    parameter int DEST_WIDTH  = ptpfw_pkg::DEST_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_page,
    input  logic [6:0]                   s_column,
    input  logic [7:0]                   s_pixels,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ptpfw_pkg::ADDR_W-1:0] m_dest_addr,
    output logic [7:0]                   m_dest_byte,
    output logic                         m_last
);

    // Burst descriptors flowing from the front end into the queue.
    logic             push;
    ptpfw_pkg::job_t  push_job;
    logic             queue_full;

    // Head of the queue as seen by the back end.
    logic             head_valid;
    ptpfw_pkg::job_t  head_job;
    logic             pop;

    // The front end classifies each transfer, updates the held group
    // members and pushes a burst when a group is complete.
    ptpfw_front #(
        .DEST_WIDTH (DEST_WIDTH)
    ) u_front (
        .clk         (aclk),
        .rstn        (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_page     (s_page),
        .in_column   (s_column),
        .in_pixels   (s_pixels),
        .q_full      (queue_full),
        .q_push      (push),
        .q_job       (push_job)
    );

    // The queue decouples acceptance from write issue.
    ptpfw_queue u_queue (
        .clk      (aclk),
        .rstn     (aresetn),
        .push     (push),
        .wr_job   (push_job),
        .full     (queue_full),
        .pop      (pop),
        .rd_valid (head_valid),
        .rd_job   (head_job)
    );

    // The back end walks each burst one write per cycle unless stalled and
    // computes the destination address as row times stride plus byte column.
    ptpfw_back #(
        .DEST_STRIDE (DEST_STRIDE)
    ) u_back (
        .clk       (aclk),
        .rstn      (aresetn),
        .q_valid   (head_valid),
        .q_job     (head_job),
        .q_pop     (pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_addr  (m_dest_addr),
        .out_byte  (m_dest_byte),
        .out_last  (m_last)
    );

endmodule

/* rtl/ptpfw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page to packed framebuffer writer checker
// Port-level properties, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`include "page_to_packed_framebuffer_writer_macros.svh"

module ptpfw_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [2:0]                   s_page,
    input logic [6:0]                   s_column,
    input logic [7:0]                   s_pixels,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [ptpfw_pkg::ADDR_W-1:0] m_dest_addr,
    input logic [7:0]                   m_dest_byte,
    input logic                         m_last
);

    // A stalled source byte keeps its contents until it is taken.
    `PTPFW_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready,
        s_valid && $stable(s_page) && $stable(s_column) && $stable(s_pixels))

    // A stalled write keeps its contents.
    `PTPFW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_dest_addr) && $stable(m_dest_byte) && $stable(m_last))

    // Every packing pattern leaves the gap bits between pixel pairs clear.
    `PTPFW_ASSERT_NOW(a_gap_bits, aclk, aresetn, m_valid, !m_dest_byte[5] && !m_dest_byte[2])

    // Nothing is offered in the first cycle after reset.
    `PTPFW_ASSERT_NOW(a_reset_idle, aclk, aresetn, $past(!aresetn), !m_valid)

endmodule

bind page_to_packed_framebuffer_writer ptpfw_checker u_ptpfw_checker (.*);

/* tb/tb_page_to_packed_framebuffer_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page to packed framebuffer writer testbench
// Checks every destination write of the writer against an in-bench predictor.
// ----------------------------------------------------------------------------
// Source bytes are fed from a queue of pending transfers by a clocked driver.
// The driver also runs the predictor at each accepted transfer and appends the
// expected burst of destination writes to a scoreboard queue. A clocked
// monitor pops that queue on each accepted write and compares address, data
// and the last flag. The render mode is changed only with the writer drained.
// Every mode is visited, and the random part is mostly whole column groups
// with random pixels, with loose bytes mixed in. The receiver also holds off
// for a long stretch once, while the driver keeps offering bytes.
// ----------------------------------------------------------------------------
module tb_page_to_packed_framebuffer_writer;

    localparam int DEST_STRIDE = ptpfw_pkg::DEST_STRIDE_DEF;
    localparam int DEST_WIDTH  = ptpfw_pkg::DEST_WIDTH_DEF;

    // Run limits and receiver hold-off shape.
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 16;

    typedef struct {
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] pixels;
    } src_byte_t;

    typedef struct {
        logic [ptpfw_pkg::ADDR_W-1:0] addr;
        logic [7:0]                   data;
        logic                         last;
    } fb_write_t;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [1:0]                   cfg_wr_data = 2'b00;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic [2:0]                   s_page      = 3'd0;
    logic [6:0]                   s_column    = 7'd0;
    logic [7:0]                   s_pixels    = 8'd0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic [ptpfw_pkg::ADDR_W-1:0] m_dest_addr;
    logic [7:0]                   m_dest_byte;
    logic                         m_last;

    // Stimulus and scoreboard.
    src_byte_t pending[$];
    fb_write_t burst_q[$];
    fb_write_t expected_writes[$];

    // Predictor state: the mode and the two held column bytes.
    ptpfw_pkg::render_mode_t mode_now    = ptpfw_pkg::MODE_DIRECT;
    logic [7:0]              keep_first  = 8'd0;
    logic [7:0]              keep_second = 8'd0;

    int  mismatches = 0;
    int  taken      = 0;
    int  cycles     = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    bit  idle_en    = 1'b1;

    page_to_packed_framebuffer_writer #(
        .DEST_STRIDE (DEST_STRIDE),
        .DEST_WIDTH  (DEST_WIDTH)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_page      (s_page),
        .s_column    (s_column),
        .s_pixels    (s_pixels),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dest_addr (m_dest_addr),
        .m_dest_byte (m_dest_byte),
        .m_last      (m_last)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Queues one destination write of the burst being built.
    task automatic add_write(input int row, input int col, input logic [7:0] data);
        fb_write_t w;
        w.addr = ptpfw_pkg::ADDR_W'(row * DEST_STRIDE + col);
        w.data = data;
        w.last = 1'b0;
        burst_q.push_back(w);
    endtask

    // Works out the writes caused by one source byte and appends them to the
    // scoreboard, with the last flag on the final one of the burst.
    task automatic predict_writes(input logic [2:0] pg, input logic [6:0] col,
                                  input logic [7:0] pix);
        int         brow;
        int         bcol;
        int         rel;
        int         c;
        int         r;
        logic [7:0] v;
        logic [7:0] b1;
        logic [7:0] b2;
        fb_write_t  w;
        burst_q.delete();
        case (mode_now)
            ptpfw_pkg::MODE_DIRECT, ptpfw_pkg::MODE_CENTERED: begin
                brow = (mode_now == ptpfw_pkg::MODE_CENTERED) ? ptpfw_pkg::CENTER_Y0 : 0;
                bcol = (mode_now == ptpfw_pkg::MODE_CENTERED) ? ptpfw_pkg::CENTER_X0 / 3 : 0;
                if (int'(col) == ptpfw_pkg::SRC_WIDTH - 1) begin
                    // The lone last column lands just right of the final group.
                    for (int b = 0; b < 8; b++) begin
                        add_write(brow + 8 * int'(pg) + b, bcol + ptpfw_pkg::SRC_WIDTH / 3,
                                  pix[b] ? ptpfw_pkg::BYTE_FIRST : 8'h00);
                    end
                end else if (int'(col) < (ptpfw_pkg::SRC_WIDTH / 3) * 3) begin
                    case (int'(col) % 3)
                        0: keep_first = pix;
                        1: keep_second = pix;
                        default: begin
                            for (int b = 0; b < 8; b++) begin
                                v = (keep_first[b]  ? ptpfw_pkg::BYTE_FIRST  : 8'h00) |
                                    (keep_second[b] ? ptpfw_pkg::BYTE_SECOND : 8'h00) |
                                    (pix[b]         ? ptpfw_pkg::BYTE_THIRD  : 8'h00);
                                add_write(brow + 8 * int'(pg) + b,
                                          bcol + int'(col) / 3, v);
                            end
                        end
                    endcase
                end
            end
            ptpfw_pkg::MODE_CROP: begin
                if (int'(col) >= ptpfw_pkg::CROP_X0 &&
                    int'(col) < ptpfw_pkg::CROP_X0 + ptpfw_pkg::CROP_W &&
                    int'(col) < ptpfw_pkg::SRC_WIDTH) begin
                    rel = int'(col) - ptpfw_pkg::CROP_X0;
                    case (rel % 3)
                        0: keep_first = pix;
                        1: keep_second = pix;
                        default: begin
                            c = 2 * (rel / 3);
                            for (int b = 0; b < 8; b++) begin
                                b1 = (keep_first[b]  ? ptpfw_pkg::BYTE_WIDE_FIRST : 8'h00) |
                                     (keep_second[b] ? ptpfw_pkg::BYTE_THIRD      : 8'h00);
                                b2 = (keep_second[b] ? ptpfw_pkg::BYTE_FIRST      : 8'h00) |
                                     (pix[b]         ? ptpfw_pkg::BYTE_WIDE_THIRD : 8'h00);
                                r  = 16 * int'(pg) + 2 * b;
                                add_write(r,     c,     b1);
                                add_write(r,     c + 1, b2);
                                add_write(r + 1, c,     b1);
                                add_write(r + 1, c + 1, b2);
                            end
                        end
                    endcase
                end
            end
            default: begin
                if (int'(col) < (ptpfw_pkg::SRC_WIDTH / 2) * 2) begin
                    if (!col[0]) begin
                        keep_first = pix;
                    end else begin
                        c = (DEST_WIDTH - ptpfw_pkg::STRETCH_SPAN) / 6 + int'(col) / 2;
                        for (int b = 0; b < 8; b++) begin
                            v = (keep_first[b] ? ptpfw_pkg::BYTE_WIDE_FIRST : 8'h00) |
                                (pix[b]        ? ptpfw_pkg::BYTE_THIRD      : 8'h00);
                            add_write(16 * int'(pg) + 2 * b,     c, v);
                            add_write(16 * int'(pg) + 2 * b + 1, c, v);
                        end
                    end
                end
            end
        endcase
        foreach (burst_q[i]) begin
            w = burst_q[i];
            w.last = (i == burst_q.size() - 1);
            expected_writes.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_item(input logic [2:0] pg, input logic [6:0] col,
                             input logic [7:0] pix);
        src_byte_t it;
        it.page   = pg;
        it.column = col;
        it.pixels = pix;
        pending.push_back(it);
    endtask

    // Pixel bytes lean toward all clear and all set now and then.
    function automatic logic [7:0] pick_pixels();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Waits until no transfer is pending or in flight and the scoreboard is
    // empty. Sampled on the falling edge so the clocked processes have settled.
    task automatic drain();
        do begin
            @(negedge aclk);
        end while (!(pending.size() == 0 && !s_valid && expected_writes.size() == 0));
    endtask

    // Mode writes happen only with the writer idle. Held bytes cause no
    // writes, so a settling wait lets the front end finish with them.
    task automatic set_mode(input ptpfw_pkg::render_mode_t mode);
        drain();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        mode_now     = mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // Mostly whole column groups for the current mode, in order, with random
    // pages and pixels. About one choice in seven is a loose byte at any
    // column, which breaks groups and exercises the ignored columns.
    task automatic queue_random(input ptpfw_pkg::render_mode_t mode, input int count);
        int         n;
        int         g;
        logic [2:0] pg;
        n = 0;
        while (n < count) begin
            pg = 3'($urandom_range(7));
            if ($urandom_range(99) < 15) begin
                push_item(pg, 7'($urandom_range(127)), pick_pixels());
                n++;
            end else begin
                case (mode)
                    ptpfw_pkg::MODE_DIRECT, ptpfw_pkg::MODE_CENTERED: begin
                        g = $urandom_range(ptpfw_pkg::SRC_WIDTH / 3);
                        if (g == ptpfw_pkg::SRC_WIDTH / 3) begin
                            push_item(pg, 7'(ptpfw_pkg::SRC_WIDTH - 1), pick_pixels());
                            n++;
                        end else begin
                            for (int k = 0; k < 3; k++)
                                push_item(pg, 7'(3 * g + k), pick_pixels());
                            n += 3;
                        end
                    end
                    ptpfw_pkg::MODE_CROP: begin
                        g = $urandom_range(ptpfw_pkg::CROP_W / 3 - 1);
                        for (int k = 0; k < 3; k++)
                            push_item(pg, 7'(ptpfw_pkg::CROP_X0 + 3 * g + k),
                                      pick_pixels());
                        n += 3;
                    end
                    default: begin
                        g = $urandom_range(ptpfw_pkg::SRC_WIDTH / 2 - 1);
                        for (int k = 0; k < 2; k++)
                            push_item(pg, 7'(2 * g + k), pick_pixels());
                        n += 2;
                    end
                endcase
            end
        end
    endtask

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Source driver: presents pending bytes, holds each one until its
    // transfer, and predicts the writes at the edge where it is taken.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : source_drive
        src_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_writes(s_page, s_column, s_pixels);
                taken <= taken + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending.size() != 0 && !(idle_en && $urandom_range(99) < 8)) begin
                    nxt = pending.pop_front();
                    s_valid  <= 1'b1;
                    s_page   <= nxt.page;
                    s_column <= nxt.column;
                    s_pixels <= nxt.pixels;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Write receiver: random back-pressure, plus one long hold-off once enough
    // bytes have gone in, so the burst queue fills and s_ready drops.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !(idle_en && $urandom_range(99) < 8);
        end
    end

    // ------------------------------------------------------------------------
    // Write monitor: each accepted write must match the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : write_monitor
        fb_write_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_writes.size() == 0) begin
                flag_mismatch($sformatf("unexpected write addr %0d data %02h last %0b",
                                        m_dest_addr, m_dest_byte, m_last));
            end else begin
                want = expected_writes.pop_front();
                if (m_dest_addr !== want.addr)
                    flag_mismatch($sformatf("addr %0d, expected %0d",
                                            m_dest_addr, want.addr));
                if (m_dest_byte !== want.data)
                    flag_mismatch($sformatf("data %02h at addr %0d, expected %02h",
                                            m_dest_byte, want.addr, want.data));
                if (m_last !== want.last)
                    flag_mismatch($sformatf("last %0b at addr %0d, expected %0b",
                                            m_last, want.addr, want.last));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("page_to_packed_framebuffer_writer test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Direct mode straight out of reset: a full group, the lone last
        // column, a column beyond the source width and the final group.
        push_item(3'd0, 7'd0,  8'hFF);
        push_item(3'd0, 7'd1,  8'h00);
        push_item(3'd0, 7'd2,  8'hA5);
        push_item(3'd7, 7'd99, 8'h81);
        push_item(3'd3, 7'd127, 8'hFF);
        push_item(3'd7, 7'd96, 8'h5A);
        push_item(3'd7, 7'd97, 8'hC3);
        push_item(3'd7, 7'd98, 8'h3C);

        // Crop: first and last groups of the window, columns just outside it,
        // then a group-final byte alone that reuses the stale held bytes.
        set_mode(ptpfw_pkg::MODE_CROP);
        push_item(3'd0, 7'd6,  8'h0F);
        push_item(3'd0, 7'd7,  8'hF0);
        push_item(3'd0, 7'd8,  8'h55);
        push_item(3'd7, 7'd90, 8'hFF);
        push_item(3'd7, 7'd91, 8'hFF);
        push_item(3'd7, 7'd92, 8'hFF);
        push_item(3'd1, 7'd5,  8'hAA);
        push_item(3'd1, 7'd93, 8'h77);
        push_item(3'd4, 7'd11, 8'h99);

        // Stretch: last and first pairs, a lone pair-final byte, and a held
        // byte that is carried over into the next mode.
        set_mode(ptpfw_pkg::MODE_STRETCH);
        push_item(3'd7, 7'd98, 8'h3C);
        push_item(3'd7, 7'd99, 8'hC3);
        push_item(3'd0, 7'd0,  8'hE7);
        push_item(3'd0, 7'd1,  8'h18);
        push_item(3'd2, 7'd1,  8'h42);
        push_item(3'd5, 7'd2,  8'hB4);

        // Centered: the group uses the byte held in stretch mode as its first.
        set_mode(ptpfw_pkg::MODE_CENTERED);
        push_item(3'd0, 7'd1,  8'h0F);
        push_item(3'd0, 7'd2,  8'hF0);
        push_item(3'd7, 7'd99, 8'hFF);

        // Random part. The long receiver hold-off falls in the first phase.
        set_mode(ptpfw_pkg::MODE_CROP);
        queue_random(ptpfw_pkg::MODE_CROP, 35);

        set_mode(ptpfw_pkg::MODE_DIRECT);
        idle_en = 1'b0;
        queue_random(ptpfw_pkg::MODE_DIRECT, 30);
        drain();
        idle_en = 1'b1;

        set_mode(ptpfw_pkg::MODE_STRETCH);
        queue_random(ptpfw_pkg::MODE_STRETCH, 30);
        set_mode(ptpfw_pkg::MODE_CENTERED);
        queue_random(ptpfw_pkg::MODE_CENTERED, 30);
        set_mode(ptpfw_pkg::MODE_CROP);
        queue_random(ptpfw_pkg::MODE_CROP, 30);
        set_mode(ptpfw_pkg::MODE_DIRECT);
        queue_random(ptpfw_pkg::MODE_DIRECT, 30);

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("page_to_packed_framebuffer_writer test passed");
        end else begin
            $display("page_to_packed_framebuffer_writer test failed");
        end
        $finish;
    end

endmodule

/* page_to_packed_framebuffer_writer.f */
+incdir+rtl
rtl/ptpfw_pkg.sv
rtl/ptpfw_front.sv
rtl/ptpfw_queue.sv
rtl/ptpfw_back.sv
rtl/page_to_packed_framebuffer_writer.sv
rtl/ptpfw_checker.sv
tb/tb_page_to_packed_framebuffer_writer.sv
